// ===== rtl/core/windowed_rms_of_samples_defines.svh =====
// Assertion macros shared by the checker.
`ifndef WINDOWED_RMS_OF_SAMPLES_DEFINES_SVH
`define WINDOWED_RMS_OF_SAMPLES_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define WRMS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define WRMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define WRMS_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wrms_pkg.sv =====
`default_nettype none
package wrms_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int RMS_W          = 16;
   localparam int WINDOW_LEN_DEF = 256;
   localparam int ROOT_STEPS     = RMS_W;

   // Entry handed from the front queue to the back sequencer.
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_OLD,
      ST_SUM,
      ST_ROOT,
      ST_OUT
   } back_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/wrms_stream_ifs.sv =====
`default_nettype none
interface wrms_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wrms_pkg::SAMPLE_W-1:0] accel_z_raw;

   modport source (output valid, output accel_z_raw, input ready);
   modport sink (input valid, input accel_z_raw, output ready);
endinterface

interface wrms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wrms_pkg::RMS_W-1:0]    rms_counts;

   modport source (output valid, output rms_counts, input ready);
   modport sink (input valid, input rms_counts, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/windowed_rms_of_samples.sv =====
// Moving-window RMS of raw accelerometer Z samples. Each req beat carries one
// signed 16-bit sample; each rsp beat returns floor(sqrt(floor(sum/WINDOW_LEN)))
// over the last WINDOW_LEN samples, in raw counts (0..32768), one rsp beat per
// req beat and in order. Samples not yet written count as zero, so the first
// results after reset ramp up. A two-entry queue takes req beats while the
// back end works, and an output register holds the result until rsp ready.
// Each beat steps in order through a pop, the store read, capturing the old
// square and writing the new sample, updating the sum of squares, the
// bit-per-cycle square root, and loading the output register once it is free.
// Ready after reset is immediate; no clearing pass runs.
`default_nettype none
module windowed_rms_of_samples #(
   parameter int WINDOW_LEN = wrms_pkg::WINDOW_LEN_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   wrms_req_if.sink    req_if,
   wrms_rsp_if.source  rsp_if
);

   wrms_pkg::item_type head;
   logic               pop;

   // Front: accept req beats and queue them.
   wrms_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .head   (head),
      .pop    (pop)
   );

   // Back: update the window and the running sum, then extract the root.
   wrms_back #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
`default_nettype wire

// ===== rtl/core/wrms_ram.sv =====
`default_nettype none
module wrms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/wrms_front.sv =====
`default_nettype none
module wrms_front (
   input  wire logic              clock,
   input  wire logic              reset,
   wrms_req_if.sink               req_if,
   output wrms_pkg::item_type     head,
   input  wire logic              pop
);

   logic                                 wr_ptr_ff, wr_ptr_in;
   logic                                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]                           count_ff, count_in;
   logic signed [wrms_pkg::SAMPLE_W-1:0] slot_ff [2];
   logic                                 push;
   logic                                 take;

   assign req_if.ready = (count_ff != 2'd2);
   assign push         = req_if.valid && req_if.ready;
   assign take         = pop && (count_ff != 2'd0);

   assign head.valid  = (count_ff != 2'd0);
   assign head.sample = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_if.accel_z_raw;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/wrms_back.sv =====
`default_nettype none
module wrms_back #(
   parameter int WINDOW_LEN = wrms_pkg::WINDOW_LEN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wrms_pkg::item_type head,
   output logic                   pop,
   wrms_rsp_if.source             rsp_if
);

   localparam int AW    = $clog2(WINDOW_LEN);
   localparam int SUM_W = 31 + AW;
   localparam int ACC_W = 33 + AW;
   localparam int RW_W  = 17 + AW;
   localparam int SQ_W  = 31;
   localparam int KW    = $clog2(wrms_pkg::ROOT_STEPS);
   localparam int SW    = wrms_pkg::SAMPLE_W;
   localparam int OW    = wrms_pkg::RMS_W;

   localparam logic [AW-1:0]    LAST_POS = AW'(WINDOW_LEN - 1);
   localparam logic [ACC_W-1:0] WIN_ACC  = ACC_W'(WINDOW_LEN);
   localparam logic [RW_W-1:0]  WIN_RW   = RW_W'(WINDOW_LEN);
   localparam logic [KW-1:0]    K_TOP    = KW'(wrms_pkg::ROOT_STEPS - 1);

   wrms_pkg::back_state_type state_ff, state_in;

   logic signed [SW-1:0] sample_ff, sample_in;
   logic [SQ_W-1:0]      new_sq_ff, new_sq_in;
   logic [SQ_W-1:0]      old_sq_ff, old_sq_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic                 wrapped_ff, wrapped_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [OW-1:0]        root_ff, root_in;
   logic [ACC_W-1:0]     sqw_ff, sqw_in;
   logic [RW_W-1:0]      rw_ff, rw_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]        rms_ff, rms_in;

   logic                 ram_re, ram_we;
   logic [SW-1:0]        ram_rdata;
   logic signed [2*SW-1:0] new_prod, old_prod;
   logic [ACC_W-1:0]     cand;
   logic                 cand_fits;
   logic                 out_free;

   wrms_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW_LEN)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (pos_ff),
      .wdata (sample_ff),
      .re    (ram_re),
      .raddr (pos_ff),
      .rdata (ram_rdata)
   );

   assign new_prod  = sample_ff * sample_ff;
   assign old_prod  = $signed(ram_rdata) * $signed(ram_rdata);
   assign cand      = sqw_ff + (ACC_W'(rw_ff) << (5'(k_ff) + 5'd1))
                      + (WIN_ACC << {k_ff, 1'b0});
   assign cand_fits = (cand <= ACC_W'(sum_ff));
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrms_pkg::ST_IDLE: begin
            if (head.valid) state_in = wrms_pkg::ST_READ;
         end
         wrms_pkg::ST_READ: state_in = wrms_pkg::ST_OLD;
         wrms_pkg::ST_OLD:  state_in = wrms_pkg::ST_SUM;
         wrms_pkg::ST_SUM:  state_in = wrms_pkg::ST_ROOT;
         wrms_pkg::ST_ROOT: begin
            if (k_ff == '0) state_in = wrms_pkg::ST_OUT;
         end
         wrms_pkg::ST_OUT: begin
            if (out_free) state_in = wrms_pkg::ST_IDLE;
         end
         default: state_in = wrms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      ram_re       = 1'b0;
      ram_we       = 1'b0;
      sample_in    = sample_ff;
      new_sq_in    = new_sq_ff;
      old_sq_in    = old_sq_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      wrapped_in   = wrapped_ff;
      k_in         = k_ff;
      root_in      = root_ff;
      sqw_in       = sqw_ff;
      rw_in        = rw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rms_in       = rms_ff;
      unique case (state_ff)
         wrms_pkg::ST_IDLE: begin
            pop       = head.valid;
            sample_in = head.sample;
         end
         wrms_pkg::ST_READ: begin
            ram_re    = 1'b1;
            new_sq_in = new_prod[SQ_W-1:0];
         end
         wrms_pkg::ST_OLD: begin
            // Unwritten entries read as zero until the first wrap.
            old_sq_in = wrapped_ff ? old_prod[SQ_W-1:0] : '0;
            ram_we    = 1'b1;
            if (pos_ff == LAST_POS) begin
               pos_in     = '0;
               wrapped_in = 1'b1;
            end else begin
               pos_in = pos_ff + AW'(1);
            end
         end
         wrms_pkg::ST_SUM: begin
            sum_in  = sum_ff - SUM_W'(old_sq_ff) + SUM_W'(new_sq_ff);
            k_in    = K_TOP;
            root_in = '0;
            sqw_in  = '0;
            rw_in   = '0;
         end
         wrms_pkg::ST_ROOT: begin
            // Keep this bit when window_len * root^2 stays within the sum.
            if (cand_fits) begin
               root_in = root_ff | (OW'(1) << k_ff);
               sqw_in  = cand;
               rw_in   = rw_ff + (WIN_RW << k_ff);
            end
            k_in = k_ff - KW'(1);
         end
         wrms_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rms_in       = root_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrms_pkg::ST_IDLE;
         sum_ff       <= '0;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      new_sq_ff <= new_sq_in;
      old_sq_ff <= old_sq_in;
      k_ff      <= k_in;
      root_ff   <= root_in;
      sqw_ff    <= sqw_in;
      rw_ff     <= rw_in;
      rms_ff    <= rms_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.rms_counts = rms_ff;

endmodule
`default_nettype wire

// ===== rtl/core/wrms_checker.sv =====
`default_nettype none
`include "windowed_rms_of_samples_defines.svh"
module wrms_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [wrms_pkg::RMS_W-1:0] rsp_rms_counts
);

   localparam logic [wrms_pkg::RMS_W-1:0] RMS_MAX = wrms_pkg::RMS_W'(32768);

   `WRMS_ASSERT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid, "rsp valid after reset")
   `WRMS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rms_counts), "stalled rsp beat changed")
   `WRMS_ASSERT_SAME(a_range, clock, reset, rsp_valid, rsp_rms_counts <= RMS_MAX, "rms out of range")

endmodule

bind windowed_rms_of_samples wrms_checker u_wrms_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_rms_counts (rsp_if.rms_counts)
);
`default_nettype wire

// ===== dv/rms_stream_checker.sv =====
`default_nettype none
module rms_stream_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic signed [wrms_pkg::SAMPLE_W-1:0] req_accel_z_raw,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic [wrms_pkg::RMS_W-1:0]          rsp_rms_counts,
   output int                                       rms_errors,
   output int                                       rms_outstanding
);

   localparam int DEPTH = wrms_pkg::WINDOW_LEN_DEF;

   logic signed [wrms_pkg::SAMPLE_W-1:0] window_samples [DEPTH];
   int unsigned                          fill_index;
   logic [38:0]                          square_sum;
   logic [wrms_pkg::RMS_W-1:0]           rms_due [$];
   logic [wrms_pkg::RMS_W-1:0]           rms_head;

   // Build the root one bit at a time from the top; 17 bits cover 32768.
   function automatic logic [16:0] floor_root(input logic [38:0] value);
      logic [16:0] root;
      logic [16:0] trial;
      root = '0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (17'd1 << b);
         if (64'(trial) * 64'(trial) <= 64'(value))
            root = trial;
      end
      return root;
   endfunction

   // Overwrite the oldest sample, update the sum and return the new RMS.
   function automatic logic [wrms_pkg::RMS_W-1:0] window_rms_after(
      input logic signed [wrms_pkg::SAMPLE_W-1:0] sample
   );
      longint      old_square;
      longint      new_square;
      logic [16:0] root;
      old_square = longint'(window_samples[fill_index]) * longint'(window_samples[fill_index]);
      new_square = longint'(sample) * longint'(sample);
      square_sum = square_sum - old_square[38:0] + new_square[38:0];
      window_samples[fill_index] = sample;
      fill_index = (fill_index + 1) % DEPTH;
      root = floor_root(square_sum / DEPTH);
      return root[wrms_pkg::RMS_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (window_samples[i])
            window_samples[i] = '0;
         fill_index = 0;
         square_sum = '0;
         rms_due.delete();
         rms_errors = 0;
         rms_outstanding <= 0;
      end else begin
         // Check the rsp beat first, so a beat can never match a sample taken on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (rms_due.size() == 0) begin
               if (rms_errors < 10)
                  $display("rms beat with nothing due: got %0d", rsp_rms_counts);
               rms_errors++;
            end else begin
               rms_head = rms_due.pop_front();
               if (rsp_rms_counts !== rms_head) begin
                  if (rms_errors < 10)
                     $display("rms mismatch: expected %0d got %0d", rms_head, rsp_rms_counts);
                  rms_errors++;
               end
            end
         end
         if (req_valid && req_ready)
            rms_due.push_back(window_rms_after(req_accel_z_raw));
         rms_outstanding <= rms_due.size();
      end
   end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;

   // Length of the one long rsp stall, in cycles.
   localparam int LONG_HOLD   = 400;
   // Samples per idling phase; three phases make up the run.
   localparam int PHASE_ITEMS = 470;

   typedef enum int unsigned {
      MIX_FULL_RANGE,
      MIX_LOW_LEVEL,
      MIX_EXTREME,
      MIX_NEAR_FULL_SCALE,
      MIX_BURST
   } sample_mix_type;

   logic clock = 1'b0;
   logic reset;

   // Free-running clock, period 2.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   wrms_req_if req_chan ();
   wrms_rsp_if rsp_chan ();

   windowed_rms_of_samples u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   int rms_errors;
   int rms_outstanding;

   rms_stream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_accel_z_raw (req_chan.accel_z_raw),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_rms_counts  (rsp_chan.rms_counts),
      .rms_errors      (rms_errors),
      .rms_outstanding (rms_outstanding)
   );

   // Idle odds in percent, per cycle, for each side.
   int   send_gap_pct;
   int   take_gap_pct;
   // Ask the rsp side for its one long stall.
   logic hold_request;
   int   items_sent;

   // Drive rsp ready: random idling, plus one long stall on request.
   // Count the stall here so the sender keeps offering beats meanwhile.
   initial begin : rsp_side
      int hold_left;
      bit hold_taken;
      hold_left      = 0;
      hold_taken     = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= take_gap_pct);
         end
      end
   end

   // Offer one sample, idling first at random, and hold it until accepted.
   // Leave valid high on return; the next call or a drain lowers it.
   task automatic send_sample(input logic [wrms_pkg::SAMPLE_W-1:0] value);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.accel_z_raw <= value;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted RMS has come back.
   // The first edge lets the checker count the beat just accepted.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (rms_outstanding != 0)
         @(posedge clock);
   endtask

   function automatic logic [wrms_pkg::SAMPLE_W-1:0] pick_sample(input sample_mix_type mix);
      logic [wrms_pkg::SAMPLE_W-1:0] value;
      case (mix)
         MIX_LOW_LEVEL: begin
            value = 16'($urandom_range(511)) - 16'd256;
         end
         MIX_EXTREME: begin
            case ($urandom_range(3))
               0:       value = 16'h8000;
               1:       value = 16'h7FFF;
               2:       value = 16'hFFFF;
               default: value = 16'h0000;
            endcase
         end
         MIX_NEAR_FULL_SCALE: begin
            if ($urandom_range(1) == 0)
               value = 16'h8000 + 16'($urandom_range(63));
            else
               value = 16'h7FFF - 16'($urandom_range(63));
         end
         default: begin
            value = 16'($urandom);
         end
      endcase
      return value;
   endfunction

   // Send random samples until the running total reaches the target.
   // Mix full-range noise with quiet and loud stretches and constant bursts,
   // so the RMS both settles and swings across the whole output range.
   task automatic send_random_until(input int target);
      sample_mix_type                mix;
      logic [wrms_pkg::SAMPLE_W-1:0] value;
      int                            burst_len;
      while (items_sent < target) begin
         mix = sample_mix_type'($urandom_range(MIX_BURST));
         if (mix == MIX_BURST) begin
            value     = pick_sample(sample_mix_type'($urandom_range(MIX_NEAR_FULL_SCALE)));
            burst_len = $urandom_range(40, 4);
            repeat (burst_len)
               send_sample(value);
         end else begin
            send_sample(pick_sample(mix));
         end
      end
   endtask

   logic [wrms_pkg::SAMPLE_W-1:0] directed_samples [20] = '{
      16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFE,
      16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h4000,
      16'hC000, 16'h0800, 16'hF800, 16'h0010, 16'hFFF0, 16'h0000
   };

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.accel_z_raw = '0;
      hold_request         = 1'b0;
      items_sent           = 0;
      send_gap_pct         = 24;
      take_gap_pct         = 80;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles little, receiver a lot.
      // Start from the cleared window: extremes and bit patterns ramp the RMS up.
      foreach (directed_samples[i])
         send_sample(directed_samples[i]);

      // Fill the whole window with the most negative sample: the RMS reaches
      // 32768, and the write position wraps on the way.
      repeat (wrms_pkg::WINDOW_LEN_DEF)
         send_sample(16'h8000);

      // Stall the rsp side for a long stretch while beats keep coming, so the
      // block fills and pushes back on req.
      hold_request = 1'b1;
      repeat (40)
         send_sample(pick_sample(MIX_FULL_RANGE));

      send_random_until(PHASE_ITEMS);
      drain_results();

      // Phase two: roles swapped.
      send_gap_pct = 80;
      take_gap_pct = 24;
      send_random_until(2 * PHASE_ITEMS);
      drain_results();

      // Phase three: no idling on either side.
      send_gap_pct = 0;
      take_gap_pct = 0;
      send_random_until(3 * PHASE_ITEMS);
      drain_results();

      // Let any stray beat show up before the verdict.
      repeat (60) @(posedge clock);

      if (rms_errors == 0 && rms_outstanding == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // Watchdog: well past the slowest legal run.
   initial begin
      #2000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/wrms_pkg.sv
rtl/core/wrms_stream_ifs.sv
rtl/core/wrms_ram.sv
rtl/core/wrms_front.sv
rtl/core/wrms_back.sv
rtl/core/windowed_rms_of_samples.sv
rtl/core/wrms_checker.sv
dv/rms_stream_checker.sv
dv/tb_top.sv
